// ----- sv/conv1d_pkg.sv -----
// Shared types and constants for the 1-D convolution forward unit.
// No dependencies; used by every module of the block.
`default_nettype none
package conv1d_pkg;

  localparam int MAX_IN_CHANNELS  = 8;
  localparam int MAX_OUT_CHANNELS = 8;
  localparam int MAX_TAPS         = 16;
  localparam int MAX_LENGTH       = 256;

  localparam int CH_W     = 3;   // out_chan / in_chan field width
  localparam int TAP_W    = 4;   // tap_index field width
  localparam int POS_W    = 8;   // position field width
  localparam int WADDR_W  = $clog2(MAX_OUT_CHANNELS * MAX_IN_CHANNELS * MAX_TAPS);
  localparam int SADDR_W  = $clog2(MAX_IN_CHANNELS * MAX_LENGTH);
  localparam int PIDX_W   = 12;  // padded sample index, position*stride + tap
  localparam int PADDED_W = 10;  // sequence length plus both pads
  localparam int ACC_W    = 40;  // bias plus 128 full-scale products
  localparam int ADDR_W   = 5;   // APB byte address

  // request commands
  localparam logic [1:0] CMD_LOAD_WEIGHT = 2'd0;
  localparam logic [1:0] CMD_LOAD_BIAS   = 2'd1;
  localparam logic [1:0] CMD_LOAD_SAMPLE = 2'd2;
  localparam logic [1:0] CMD_COMPUTE     = 2'd3;

  // register indexes
  localparam logic [2:0] REG_IN_CH   = 3'd0;
  localparam logic [2:0] REG_OUT_CH  = 3'd1;
  localparam logic [2:0] REG_TAPS    = 3'd2;
  localparam logic [2:0] REG_STRIDE  = 3'd3;
  localparam logic [2:0] REG_PAD     = 3'd4;
  localparam logic [2:0] REG_SEQ_LEN = 3'd5;

  // configuration, already clamped into range
  typedef struct packed {
    logic [3:0] nin;
    logic [3:0] nout;
    logic [4:0] taps;
    logic [3:0] stride;
    logic [3:0] pad;
    logic [8:0] seq;
  } cfg_t;

  typedef struct packed {
    logic              accept;     // request taken this cycle
    logic              check;      // range check and accumulator preset
    logic              mac_valid;  // issue one multiply-accumulate
    logic [CH_W-1:0]   mac_chan;
    logic [TAP_W-1:0]  mac_tap;
    logic              out_load;   // move result into output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic range_bad;
    logic pipe_busy;
  } dp_stat_t;

endpackage
`default_nettype wire

// ----- sv/conv1d_regs.sv -----
// APB configuration registers with range clamping.
// Depends on conv1d_pkg.
`default_nettype none
module conv1d_regs (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [conv1d_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready,
  output conv1d_pkg::cfg_t                   cfg
);

  logic [3:0] in_ch;
  logic [3:0] out_ch;
  logic [4:0] taps;
  logic [3:0] stride;
  logic [3:0] pad;
  logic [8:0] seq_len;
  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_ch   <= 4'd1;
      out_ch  <= 4'd1;
      taps    <= 5'd1;
      stride  <= 4'd1;
      pad     <= 4'd0;
      seq_len <= 9'd1;
    end else if (wr) begin
      unique case (idx)
        conv1d_pkg::REG_IN_CH:   in_ch   <= pwdata[3:0];
        conv1d_pkg::REG_OUT_CH:  out_ch  <= pwdata[3:0];
        conv1d_pkg::REG_TAPS:    taps    <= pwdata[4:0];
        conv1d_pkg::REG_STRIDE:  stride  <= pwdata[3:0];
        conv1d_pkg::REG_PAD:     pad     <= pwdata[3:0];
        conv1d_pkg::REG_SEQ_LEN: seq_len <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      conv1d_pkg::REG_IN_CH:   prdata = {28'd0, in_ch};
      conv1d_pkg::REG_OUT_CH:  prdata = {28'd0, out_ch};
      conv1d_pkg::REG_TAPS:    prdata = {27'd0, taps};
      conv1d_pkg::REG_STRIDE:  prdata = {28'd0, stride};
      conv1d_pkg::REG_PAD:     prdata = {28'd0, pad};
      conv1d_pkg::REG_SEQ_LEN: prdata = {23'd0, seq_len};
      default:                 prdata = 32'd0;
    endcase
  end

  // zero reads as one, anything above the store size as the maximum
  always_comb begin
    cfg.nin = (in_ch == 4'd0) ? 4'd1 :
              (in_ch > 4'(conv1d_pkg::MAX_IN_CHANNELS)) ?
              4'(conv1d_pkg::MAX_IN_CHANNELS) : in_ch;
    cfg.nout = (out_ch == 4'd0) ? 4'd1 :
               (out_ch > 4'(conv1d_pkg::MAX_OUT_CHANNELS)) ?
               4'(conv1d_pkg::MAX_OUT_CHANNELS) : out_ch;
    cfg.taps = (taps == 5'd0) ? 5'd1 :
               (taps > 5'(conv1d_pkg::MAX_TAPS)) ? 5'(conv1d_pkg::MAX_TAPS) : taps;
    cfg.stride = (stride == 4'd0) ? 4'd1 : stride;
    cfg.pad    = pad;
    cfg.seq = (seq_len == 9'd0) ? 9'd1 :
              (seq_len > 9'(conv1d_pkg::MAX_LENGTH)) ?
              9'(conv1d_pkg::MAX_LENGTH) : seq_len;
  end

endmodule
`default_nettype wire

// ----- sv/conv1d_ctrl.sv -----
// Sequencer for the convolution unit: request handshake, channel/tap loop,
// pipeline drain and output handshake. Depends on conv1d_pkg.
`default_nettype none
module conv1d_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire conv1d_pkg::cfg_t       cfg,
  input  wire logic                   item_valid,
  output logic                        item_stall,
  input  wire logic [1:0]             command,
  output logic                        res_valid,
  input  wire logic                   res_stall,
  input  wire conv1d_pkg::dp_stat_t   stat,
  output conv1d_pkg::ctrl_cmd_t       cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;
  localparam logic [1:0] ST_DRAIN = 2'd3;

  logic [1:0]                        state;
  logic [1:0]                        state_next;
  logic [conv1d_pkg::CH_W-1:0]       chan;
  logic [conv1d_pkg::TAP_W-1:0]      tap;
  logic                              last_tap;
  logic                              last_chan;
  logic                              accept;
  logic                              out_free;

  assign item_stall = (state != ST_IDLE);
  assign accept     = item_valid && !item_stall;
  assign last_tap   = ({1'b0, tap} == cfg.taps - 5'd1);
  assign last_chan  = ({1'b0, chan} == cfg.nin - 4'd1);
  assign out_free   = !res_valid || !res_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && command == conv1d_pkg::CMD_COMPUTE) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        state_next = stat.range_bad ? ST_DRAIN : ST_RUN;
      end
      ST_RUN: begin
        if (last_tap && last_chan) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!stat.pipe_busy && out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      chan      <= '0;
      tap       <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CHECK) begin
        chan <= '0;
        tap  <= '0;
      end else if (state == ST_RUN) begin
        if (last_tap) begin
          tap  <= '0;
          chan <= chan + 1'b1;
        end else begin
          tap <= tap + 1'b1;
        end
      end
      if (cmd.out_load)              res_valid <= 1'b1;
      else if (res_valid && !res_stall) res_valid <= 1'b0;
    end
  end

  always_comb begin
    cmd.accept    = accept;
    cmd.check     = (state == ST_CHECK);
    cmd.mac_valid = (state == ST_RUN);
    cmd.mac_chan  = chan;
    cmd.mac_tap   = tap;
    cmd.out_load  = (state == ST_DRAIN) && !stat.pipe_busy && out_free;
  end

endmodule
`default_nettype wire

// ----- sv/conv1d_dp.sv -----
// Datapath: weight, bias and sample stores, padding logic, one pipelined
// multiply-accumulate and the output register. Depends on conv1d_pkg.
`default_nettype none
module conv1d_dp (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire conv1d_pkg::cfg_t                  cfg,
  input  wire conv1d_pkg::ctrl_cmd_t             cmd,
  input  wire logic [1:0]                        command,
  input  wire logic [conv1d_pkg::CH_W-1:0]       out_chan,
  input  wire logic [conv1d_pkg::CH_W-1:0]       in_chan,
  input  wire logic [conv1d_pkg::TAP_W-1:0]      tap_index,
  input  wire logic [conv1d_pkg::POS_W-1:0]      position,
  input  wire logic signed [31:0]                value,
  output conv1d_pkg::dp_stat_t                   stat,
  output logic signed [31:0]                     result,
  output logic                                   range_error
);

  localparam int ACC_W = conv1d_pkg::ACC_W;

  logic [15:0] weight_mem [conv1d_pkg::MAX_OUT_CHANNELS*conv1d_pkg::MAX_IN_CHANNELS*
                           conv1d_pkg::MAX_TAPS];
  logic [15:0] sample_mem [conv1d_pkg::MAX_IN_CHANNELS*conv1d_pkg::MAX_LENGTH];
  logic [31:0] bias_reg   [conv1d_pkg::MAX_OUT_CHANNELS];

  logic [conv1d_pkg::CH_W-1:0]     oc_q;
  logic [conv1d_pkg::PIDX_W-1:0]   base_q;
  logic                            err_q;
  logic [15:0]                     val_sat;
  logic                            load;

  logic [conv1d_pkg::PADDED_W-1:0] padded;
  logic [conv1d_pkg::PADDED_W-1:0] span;

  logic [conv1d_pkg::PIDX_W-1:0]   pidx;
  logic [conv1d_pkg::PIDX_W-1:0]   sidx;
  logic                            in_seq;
  logic [conv1d_pkg::WADDR_W-1:0]  w_addr;
  logic [conv1d_pkg::SADDR_W-1:0]  s_addr;

  logic                            v1;
  logic                            z1;
  logic signed [15:0]              w_rd;
  logic signed [15:0]              s_rd;
  logic                            v2;
  logic signed [31:0]              prod;
  logic signed [ACC_W-1:0]         acc;

  assign load = cmd.accept;

  always_comb begin
    if (value > 32'sd32767)       val_sat = 16'h7FFF;
    else if (value < -32'sd32768) val_sat = 16'h8000;
    else                          val_sat = value[15:0];
  end

  // padded sequence and the largest start index that still fits the kernel
  assign padded = {1'b0, cfg.seq} + {5'd0, cfg.pad, 1'b0};
  assign span   = padded - {5'd0, cfg.taps};

  always_comb begin
    stat.range_bad = ({1'b0, oc_q} >= cfg.nout) ||
                     (padded < {5'd0, cfg.taps}) ||
                     (base_q > {2'd0, span});
    stat.pipe_busy = v1 || v2;
  end

  // taps landing in either pad read as zero
  assign pidx   = base_q + {8'd0, cmd.mac_tap};
  assign sidx   = pidx - {8'd0, cfg.pad};
  assign in_seq = (pidx >= {8'd0, cfg.pad}) && (sidx < {3'd0, cfg.seq});
  assign w_addr = {oc_q, cmd.mac_chan, cmd.mac_tap};
  assign s_addr = {cmd.mac_chan, sidx[conv1d_pkg::POS_W-1:0]};

  always_ff @(posedge clk) begin
    if (load && command == conv1d_pkg::CMD_LOAD_WEIGHT)
      weight_mem[{out_chan, in_chan, tap_index}] <= val_sat;
    w_rd <= weight_mem[w_addr];
  end

  always_ff @(posedge clk) begin
    if (load && command == conv1d_pkg::CMD_LOAD_SAMPLE)
      sample_mem[{in_chan, position}] <= val_sat;
    s_rd <= sample_mem[s_addr];
  end

  always_ff @(posedge clk) begin
    if (load && command == conv1d_pkg::CMD_LOAD_BIAS) bias_reg[out_chan] <= value;
    if (load) begin
      oc_q   <= out_chan;
      base_q <= conv1d_pkg::PIDX_W'(position) * conv1d_pkg::PIDX_W'(cfg.stride);
    end
    if (cmd.check) begin
      err_q <= stat.range_bad;
      acc   <= ACC_W'(signed'(bias_reg[oc_q]));
    end else if (v2) begin
      acc <= acc + ACC_W'(prod);
    end
    z1   <= !in_seq;
    prod <= w_rd * (z1 ? 16'sd0 : s_rd);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.mac_valid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      range_error <= err_q;
      if (err_q)                                  result <= 32'sd0;
      else if (acc > ACC_W'(32'sh7FFF_FFFF))      result <= 32'sh7FFF_FFFF;
      else if (acc < ACC_W'(-64'sd2147483648))    result <= 32'sh8000_0000;
      else                                        result <= acc[31:0];
    end
  end

endmodule
`default_nettype wire

// ----- sv/conv1d_multichannel_forward_unit.sv -----
// Top level of the multi-channel 1-D convolution forward unit.
// Depends on conv1d_pkg, conv1d_regs, conv1d_ctrl and conv1d_dp.
`default_nettype none
// Load requests (weight, bias, sample) are taken while idle and give no
// result. A compute request holds the input through the range check, one
// multiply-accumulate per channel and tap through the single MAC unit, and the
// drain of the read and product pipeline registers before the result register
// loads. An out-of-range request skips the multiply-accumulates and returns
// range_error with a zero result. Loads may follow while a result still waits
// on the output. Reading weights, biases or samples that were never loaded
// gives undefined results. Change configuration only when idle.
module conv1d_multichannel_forward_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [conv1d_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready,
  input  wire logic                          item_valid,
  output logic                               item_stall,
  input  wire logic [1:0]                    command,
  input  wire logic [conv1d_pkg::CH_W-1:0]   out_chan,
  input  wire logic [conv1d_pkg::CH_W-1:0]   in_chan,
  input  wire logic [conv1d_pkg::TAP_W-1:0]  tap_index,
  input  wire logic [conv1d_pkg::POS_W-1:0]  position,
  input  wire logic signed [31:0]            value,
  output logic                               res_valid,
  input  wire logic                          res_stall,
  output logic signed [31:0]                 result,
  output logic                               range_error
);

  conv1d_pkg::cfg_t       cfg;
  conv1d_pkg::ctrl_cmd_t  cmd;
  conv1d_pkg::dp_stat_t   stat;

  conv1d_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  conv1d_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .command    (command),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  conv1d_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cmd         (cmd),
    .command     (command),
    .out_chan    (out_chan),
    .in_chan     (in_chan),
    .tap_index   (tap_index),
    .position    (position),
    .value       (value),
    .stat        (stat),
    .result      (result),
    .range_error (range_error)
  );

endmodule
`default_nettype wire
